// ----- hdl/open_addressing_hash_table_assert.svh -----
// Assertion macros used by the checker of the open addressing hash table.
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// Both macros expect clk and arst_n in the scope where they are used.
`define OAHT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oaht: same-cycle check failed");

`define OAHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oaht: next-cycle check failed");

`endif

// ----- hdl/oaht_pkg.sv -----
// Types, constants and helper functions of the open addressing hash table.
`default_nettype none

package oaht_pkg;

	localparam int SIZE_W = 9;
	localparam int HASH_W = 16;
	localparam int DATUM_W = 32;
	localparam int KEYIN_W = 64;
	localparam int KEYIN_BYTES = KEYIN_W / 8;
	localparam int STATUS_W = 3;
	localparam int SLOT_W = 8;

	localparam int DEPTH_DEFAULT = 256;
	localparam int KEY_BYTES_DEFAULT = 8;
	localparam int MIN_SIZE = 17;
	localparam int RESET_SIZE = 127;

	localparam int MOD_BITS = 4;
	localparam int MOD_STEPS = HASH_W / MOD_BITS;

	localparam int THIRD_DIV = 3;
	localparam int RECIP_THIRD = 683;
	localparam int RECIP_SHIFT = 11;
	localparam int RECIP_W = 10;
	localparam int PROD_W = SIZE_W + RECIP_W;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [STATUS_W-1:0] ST_NEW = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

	typedef struct packed {
		logic command;
		logic [KEYIN_W-1:0] key_bytes;
		logic [DATUM_W-1:0] datum_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATUM_W-1:0] datum_out;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input int depth);
		logic [SIZE_W-1:0] s;
		s = v;
		if (s < SIZE_W'(MIN_SIZE)) begin
			s = SIZE_W'(MIN_SIZE);
		end
		if (int'(s) > depth) begin
			s = SIZE_W'(depth);
		end
		return s;
	endfunction

	// Largest odd below size/3; reciprocal multiply exact for 9-bit sizes.
	function automatic logic [SIZE_W-1:0] step_of(input logic [SIZE_W-1:0] s);
		logic [PROD_W-1:0] prod;
		logic [SIZE_W-1:0] p;
		prod = PROD_W'(s) * PROD_W'(RECIP_THIRD);
		p = SIZE_W'(prod >> RECIP_SHIFT);
		if (PROD_W'(p) * PROD_W'(THIRD_DIV) == PROD_W'(s)) begin
			p = p - SIZE_W'(1);
		end
		if (!p[0]) begin
			p = p - SIZE_W'(1);
		end
		return p;
	endfunction

	function automatic logic [KEYIN_W-1:0] trim_key(input logic [KEYIN_W-1:0] k,
			input int nbytes);
		logic [KEYIN_W-1:0] out;
		logic alive;
		out = '0;
		alive = 1'b1;
		for (int i = 0; i < KEYIN_BYTES; i++) begin
			alive = alive && (k[8*i +: 8] != 8'd0) && (i < nbytes);
			if (alive) begin
				out[8*i +: 8] = k[8*i +: 8];
			end
		end
		return out;
	endfunction

	function automatic logic [HASH_W-1:0] key_hash(input logic [KEYIN_W-1:0] k);
		logic [HASH_W-1:0] h;
		h = '0;
		for (int i = 0; i < KEYIN_BYTES; i += 2) begin
			h[7:0] = h[7:0] ^ k[8*i +: 8];
			h[15:8] = h[15:8] ^ k[8*(i+1) +: 8];
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/oaht_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/open_addressing_hash_table.sv -----
// Top level of the open addressing hash table with a fixed-step probe.
`default_nettype none

// A word is accepted when start is high while busy is low. After the accept the
// hash of the key is reduced modulo the table size, four quotient bits a cycle,
// and then the table RAM is probed one slot a cycle, since each probe waits on
// the registered read of the previous one; an operation makes from one probe
// up to as many probes as the table size. When busy falls the result word is
// shown on result with done high for exactly one cycle, and a new word can be
// accepted while done is high. The receiver cannot stall the result. After
// reset and after every write of the size register the block clears the valid
// marks of the slots in use, one slot a cycle, with busy high meanwhile (the
// size is 127 after reset); writes of the size register are taken at any time.
module open_addressing_hash_table #(
	parameter int TABLE_DEPTH = oaht_pkg::DEPTH_DEFAULT,
	parameter int KEY_BYTES = oaht_pkg::KEY_BYTES_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire oaht_pkg::req_t request,
	output logic busy,
	output logic done,
	output oaht_pkg::rsp_t result,
	input wire logic size_we,
	input wire logic [oaht_pkg::SIZE_W-1:0] size_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int ENTRY_W = 1 + KEY_W + oaht_pkg::DATUM_W;
	localparam int REM_W = oaht_pkg::SIZE_W + 1;
	localparam int SUM_W = (IDX_W > oaht_pkg::SIZE_W ? IDX_W : oaht_pkg::SIZE_W) + 1;
	localparam int MODCNT_W = $clog2(oaht_pkg::MOD_STEPS);
	localparam logic [oaht_pkg::SIZE_W-1:0] SIZE_AT_RESET =
		oaht_pkg::clamp_size(oaht_pkg::SIZE_W'(oaht_pkg::RESET_SIZE), TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_LOOK
	} state_t;

	state_t state_q;
	logic [oaht_pkg::SIZE_W-1:0] size_q;
	logic [oaht_pkg::SIZE_W-1:0] step_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [oaht_pkg::DATUM_W-1:0] datum_q;
	logic [oaht_pkg::HASH_W-1:0] dividend_q;
	logic [REM_W-1:0] rem_q;
	logic [MODCNT_W-1:0] mod_cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [oaht_pkg::SIZE_W-1:0] left_q;
	logic done_q;
	oaht_pkg::rsp_t result_q;

	logic [oaht_pkg::KEYIN_W-1:0] trimmed;
	logic [oaht_pkg::SIZE_W-1:0] new_size;
	logic [REM_W-1:0] rem_nx;
	logic [oaht_pkg::HASH_W-1:0] dividend_nx;
	logic [SUM_W-1:0] sum;
	logic [IDX_W-1:0] nidx;
	logic mod_last;
	logic clr_last;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic e_valid;
	logic [KEY_W-1:0] e_key;
	logic [oaht_pkg::DATUM_W-1:0] e_datum;
	logic hit_empty;
	logic hit_match;
	logic last_probe;

	oaht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign trimmed = oaht_pkg::trim_key(request.key_bytes, KEY_BYTES);
	assign new_size = oaht_pkg::clamp_size(size_data, TABLE_DEPTH);

	// Restoring remainder over MOD_BITS dividend bits at a time; the remainder stays below the size.
	always_comb begin
		logic [REM_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < oaht_pkg::MOD_BITS; i++) begin
			r = {r[REM_W-2:0], dividend_q[oaht_pkg::HASH_W-1-i]};
			if (r >= REM_W'(size_q)) begin
				r = r - REM_W'(size_q);
			end
		end
		rem_nx = r;
	end

	assign dividend_nx = dividend_q << oaht_pkg::MOD_BITS;

	always_comb begin
		sum = SUM_W'(idx_q) + SUM_W'(step_q);
		if (sum >= SUM_W'(size_q)) begin
			sum = sum - SUM_W'(size_q);
		end
	end

	assign nidx = IDX_W'(sum);
	assign mod_last = mod_cnt_q == MODCNT_W'(oaht_pkg::MOD_STEPS - 1);
	assign clr_last = SUM_W'(clr_cnt_q) + SUM_W'(1) >= SUM_W'(size_q);

	assign e_valid = ram_rdata[ENTRY_W-1];
	assign e_key = ram_rdata[oaht_pkg::DATUM_W +: KEY_W];
	assign e_datum = ram_rdata[oaht_pkg::DATUM_W-1:0];
	assign hit_empty = !e_valid;
	assign hit_match = e_valid && (e_key == key_q);
	assign last_probe = left_q == oaht_pkg::SIZE_W'(1);

	// A write lands before any read that uses it, so no forwarding is needed.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {1'b1, key_q, datum_q};
		ram_raddr = idx_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			S_MOD: begin
				ram_raddr = IDX_W'(rem_nx);
			end
			S_LOOK: begin
				ram_raddr = nidx;
				ram_we = (cmd_q == oaht_pkg::CMD_INSERT) && (hit_empty || hit_match);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			size_q <= SIZE_AT_RESET;
			step_q <= oaht_pkg::step_of(SIZE_AT_RESET);
			clr_cnt_q <= '0;
			cmd_q <= oaht_pkg::CMD_INSERT;
			key_q <= '0;
			datum_q <= '0;
			dividend_q <= '0;
			rem_q <= '0;
			mod_cnt_q <= '0;
			idx_q <= '0;
			left_q <= '0;
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (size_we) begin
				state_q <= S_CLEAR;
				size_q <= new_size;
				step_q <= oaht_pkg::step_of(new_size);
				clr_cnt_q <= '0;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_cnt_q <= clr_cnt_q + IDX_W'(1);
						if (clr_last) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (start) begin
							state_q <= S_MOD;
							cmd_q <= request.command;
							key_q <= trimmed[KEY_W-1:0];
							datum_q <= request.datum_in;
							dividend_q <= oaht_pkg::key_hash(trimmed);
							rem_q <= '0;
							mod_cnt_q <= '0;
						end
					end
					S_MOD: begin
						rem_q <= rem_nx;
						dividend_q <= dividend_nx;
						mod_cnt_q <= mod_cnt_q + MODCNT_W'(1);
						if (mod_last) begin
							state_q <= S_LOOK;
							idx_q <= IDX_W'(rem_nx);
							left_q <= size_q;
						end
					end
					S_LOOK: begin
						if (hit_empty || hit_match || last_probe) begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
							result_q.slot <= oaht_pkg::SLOT_W'(idx_q);
							result_q.datum_out <= '0;
							if (cmd_q == oaht_pkg::CMD_INSERT) begin
								if (hit_empty) begin
									result_q.status <= oaht_pkg::ST_NEW;
								end else if (hit_match) begin
									result_q.status <= oaht_pkg::ST_REPLACED;
								end else begin
									result_q.status <= oaht_pkg::ST_FULL;
								end
							end else if (hit_match) begin
								result_q.status <= oaht_pkg::ST_FOUND;
								result_q.datum_out <= e_datum;
							end else begin
								result_q.status <= oaht_pkg::ST_MISSING;
							end
						end else begin
							left_q <= left_q - oaht_pkg::SIZE_W'(1);
							idx_q <= nidx;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ----- hdl/oaht_checker.sv -----
// Port-level checker of the open addressing hash table and its bind.
`default_nettype none

`include "open_addressing_hash_table_assert.svh"

module oaht_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic size_we,
	input wire oaht_pkg::rsp_t result
);

	`OAHT_ASSERT_SAME(a_done_idle, done, !busy)
	`OAHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`OAHT_ASSERT_NEXT(a_done_single, done, !done)
	`OAHT_ASSERT_NEXT(a_size_clears, size_we, busy)
	`OAHT_ASSERT_SAME(a_datum_zero, done && (result.status != oaht_pkg::ST_FOUND), result.datum_out == '0)

endmodule

bind open_addressing_hash_table oaht_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.size_we(size_we),
	.result(result)
);

`default_nettype wire

// ----- tb/open_addressing_hash_table_test.sv -----
// Self-checking testbench of the open addressing hash table: directed and random words.
module open_addressing_hash_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 5;
	localparam int DEPTH = oaht_pkg::DEPTH_DEFAULT;
	localparam int RANDOM_WORDS = 1200;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 32;

	typedef struct {
		logic do_size;
		logic [oaht_pkg::SIZE_W-1:0] size_val;
		oaht_pkg::req_t word;
		logic typed;
		oaht_pkg::rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	oaht_pkg::req_t request = '0;
	logic busy;
	logic done;
	oaht_pkg::rsp_t result;
	logic size_we = 1'b0;
	logic [oaht_pkg::SIZE_W-1:0] size_data = '0;

	logic entry_live [DEPTH];
	logic [oaht_pkg::KEYIN_W-1:0] entry_key [DEPTH];
	logic [oaht_pkg::DATUM_W-1:0] entry_datum [DEPTH];
	int unsigned live_size;
	int unsigned probe_stride;

	oaht_pkg::rsp_t pending_replies [$];
	plan_row_t plan [$];
	logic [oaht_pkg::KEYIN_W-1:0] key_pool [$];
	int errors = 0;
	int words_sent = 0;
	int size_writes = 0;
	int status_seen [5];
	int quiet_cycles = 0;

	open_addressing_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result),
		.size_we(size_we),
		.size_data(size_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic void apply_size(input logic [oaht_pkg::SIZE_W-1:0] v);
		int unsigned s;
		int unsigned p;
		s = v;
		if (s < oaht_pkg::MIN_SIZE) begin
			s = oaht_pkg::MIN_SIZE;
		end
		if (s > DEPTH) begin
			s = DEPTH;
		end
		live_size = s;
		p = s / oaht_pkg::THIRD_DIV;
		if (p * oaht_pkg::THIRD_DIV == s) begin
			p = p - 1;
		end
		if (p % 2 == 0) begin
			p = p - 1;
		end
		probe_stride = p;
		foreach (entry_live[i]) begin
			entry_live[i] = 1'b0;
		end
	endfunction

	function automatic logic [oaht_pkg::KEYIN_W-1:0] clean_key(
			input logic [oaht_pkg::KEYIN_W-1:0] k);
		logic [oaht_pkg::KEYIN_W-1:0] kept;
		logic running;
		kept = '0;
		running = 1'b1;
		for (int i = 0; i < oaht_pkg::KEY_BYTES_DEFAULT; i++) begin
			running = running && (k[8*i +: 8] != 8'd0);
			if (running) begin
				kept[8*i +: 8] = k[8*i +: 8];
			end
		end
		return kept;
	endfunction

	function automatic oaht_pkg::rsp_t probe_table(input oaht_pkg::req_t w);
		logic [oaht_pkg::KEYIN_W-1:0] k;
		logic [oaht_pkg::HASH_W-1:0] h;
		int unsigned idx;
		int unsigned left;
		oaht_pkg::rsp_t r;
		k = clean_key(w.key_bytes);
		h = '0;
		for (int i = 0; i < oaht_pkg::KEYIN_BYTES; i++) begin
			if (i % 2 == 1) begin
				h[15:8] = h[15:8] ^ k[8*i +: 8];
			end else begin
				h[7:0] = h[7:0] ^ k[8*i +: 8];
			end
		end
		idx = h % live_size;
		left = live_size;
		while (entry_live[idx] && entry_key[idx] != k) begin
			left--;
			if (left == 0) begin
				break;
			end
			idx = (idx + probe_stride) % live_size;
		end
		r.datum_out = '0;
		r.slot = oaht_pkg::SLOT_W'(idx);
		if (w.command == oaht_pkg::CMD_INSERT) begin
			if (!entry_live[idx]) begin
				entry_live[idx] = 1'b1;
				entry_key[idx] = k;
				entry_datum[idx] = w.datum_in;
				r.status = oaht_pkg::ST_NEW;
			end else if (left != 0) begin
				entry_datum[idx] = w.datum_in;
				r.status = oaht_pkg::ST_REPLACED;
			end else begin
				r.status = oaht_pkg::ST_FULL;
			end
		end else if (entry_live[idx] && left != 0) begin
			r.datum_out = entry_datum[idx];
			r.status = oaht_pkg::ST_FOUND;
		end else begin
			r.status = oaht_pkg::ST_MISSING;
		end
		return r;
	endfunction

	function automatic logic [oaht_pkg::KEYIN_W-1:0] fresh_key();
		logic [oaht_pkg::KEYIN_W-1:0] k;
		int len;
		len = int'($urandom_range(0, oaht_pkg::KEYIN_BYTES));
		for (int i = 0; i < oaht_pkg::KEYIN_BYTES; i++) begin
			if (i < len) begin
				k[8*i +: 8] = 8'($urandom_range(1, 255));
			end else if (i == len) begin
				k[8*i +: 8] = 8'd0;
			end else begin
				k[8*i +: 8] = 8'($urandom_range(0, 255));
			end
		end
		return k;
	endfunction

	function automatic void plan_word(input logic cmd,
			input logic [oaht_pkg::KEYIN_W-1:0] key,
			input logic [oaht_pkg::DATUM_W-1:0] datum);
		plan_row_t row;
		row.do_size = 1'b0;
		row.size_val = '0;
		row.word = '{command: cmd, key_bytes: key, datum_in: datum};
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_checked(input logic cmd,
			input logic [oaht_pkg::KEYIN_W-1:0] key,
			input logic [oaht_pkg::DATUM_W-1:0] datum,
			input logic [oaht_pkg::STATUS_W-1:0] st,
			input logic [oaht_pkg::DATUM_W-1:0] dout,
			input logic [oaht_pkg::SLOT_W-1:0] where);
		plan_word(cmd, key, datum);
		plan[$].typed = 1'b1;
		plan[$].want = '{status: st, datum_out: dout, slot: where};
	endfunction

	function automatic void plan_size(input logic [oaht_pkg::SIZE_W-1:0] v);
		plan_row_t row;
		row = '{do_size: 1'b1, size_val: v, word: '0, typed: 1'b0, want: '0};
		plan.push_back(row);
	endfunction

	task automatic send_word(input oaht_pkg::req_t w, input logic typed,
			input oaht_pkg::rsp_t want);
		oaht_pkg::rsp_t guess;
		@(negedge clk);
		start <= 1'b1;
		request <= w;
		do @(posedge clk); while (busy !== 1'b0);
		guess = probe_table(w);
		pending_replies.push_back(typed ? want : guess);
		words_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
	endtask

	task automatic write_size(input logic [oaht_pkg::SIZE_W-1:0] v);
		while (busy !== 1'b0) @(negedge clk);
		size_we <= 1'b1;
		size_data <= v;
		@(negedge clk);
		size_we <= 1'b0;
		apply_size(v);
		size_writes++;
	endtask

	always @(posedge clk) begin
		oaht_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("result word with none expected: status %0d datum_out %h slot %0d",
					result.status, result.datum_out, result.slot);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				if (want.status < 5) begin
					status_seen[want.status]++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					errors++;
				end
				if (result.datum_out !== want.datum_out) begin
					$error("datum_out: expected %h, got %h", want.datum_out,
						result.datum_out);
					errors++;
				end
				if (result.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, result.slot);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && busy === 1'b0) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [oaht_pkg::SIZE_W-1:0] extremes [9];
		int random_words;
		int phase_words;
		int burst_left;
		int pick;
		logic seen_end;
		logic [oaht_pkg::SIZE_W-1:0] next_size;
		oaht_pkg::req_t w;

		extremes = '{9'd0, 9'd1, 9'd16, 9'd17, 9'd18, 9'd255, 9'd256, 9'd257, 9'd511};
		foreach (status_seen[i]) begin
			status_seen[i] = 0;
		end
		apply_size(oaht_pkg::SIZE_W'(oaht_pkg::RESET_SIZE));
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		plan_checked(oaht_pkg::CMD_SEARCH, 64'h0, 32'h1234_5678, oaht_pkg::ST_MISSING,
			'0, 8'd0);
		plan_checked(oaht_pkg::CMD_INSERT, 64'h0, 32'hFFFF_FFFF, oaht_pkg::ST_NEW,
			'0, 8'd0);
		plan_checked(oaht_pkg::CMD_SEARCH, 64'h0000_0000_0000_FF00, '0, oaht_pkg::ST_FOUND,
			32'hFFFF_FFFF, 8'd0);
		plan_checked(oaht_pkg::CMD_INSERT, 64'h0, 32'h0, oaht_pkg::ST_REPLACED, '0, 8'd0);
		plan_checked(oaht_pkg::CMD_INSERT, 64'hFF, 32'h8000_0001, oaht_pkg::ST_NEW,
			'0, 8'd1);
		plan_word(oaht_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5A5A_A5A5);
		plan_word(oaht_pkg::CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, '0);
		plan_word(oaht_pkg::CMD_INSERT, 64'h1200_0000_0000_0041, 32'h1);
		plan_word(oaht_pkg::CMD_SEARCH, 64'h41, '0);
		plan_word(oaht_pkg::CMD_SEARCH, 64'h0102_0304_0506_0708, '0);
		plan_word(oaht_pkg::CMD_INSERT, 64'h0102_0304_0506_0708, 32'hA5A5_5A5A);
		plan_size(9'd0);
		plan_checked(oaht_pkg::CMD_SEARCH, 64'h0, '0, oaht_pkg::ST_MISSING, '0, 8'd0);
		plan_word(oaht_pkg::CMD_INSERT, 64'hFF, 32'h7);
		plan_size(9'd511);
		plan_checked(oaht_pkg::CMD_INSERT, 64'hFFFF, 32'hFFFF_FFFF, oaht_pkg::ST_NEW,
			'0, 8'd255);
		plan_checked(oaht_pkg::CMD_SEARCH, 64'hFFFF, '0, oaht_pkg::ST_FOUND,
			32'hFFFF_FFFF, 8'd255);
		plan_size(9'd257);
		plan_checked(oaht_pkg::CMD_SEARCH, 64'hFFFF, '0, oaht_pkg::ST_MISSING, '0, 8'd255);
		plan_size(9'd1);
		plan_word(oaht_pkg::CMD_INSERT, 64'hFFFF, 32'h0F0F_F0F0);
		plan_size(9'd16);
		plan_size(9'd256);
		plan_size(9'd17);
		plan_word(oaht_pkg::CMD_INSERT, 64'h0, 32'h0);

		foreach (plan[i]) begin
			if (plan[i].do_size) begin
				drain();
				write_size(plan[i].size_val);
			end else begin
				send_word(plan[i].word, plan[i].typed, plan[i].want);
			end
		end

		random_words = 0;
		burst_left = 0;
		while (random_words < RANDOM_WORDS) begin
			drain();
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				next_size = extremes[$urandom_range(0, 8)];
			end else if (pick <= 6) begin
				next_size = oaht_pkg::SIZE_W'($urandom_range(17, 40));
			end else if (pick <= 8) begin
				next_size = oaht_pkg::SIZE_W'($urandom_range(41, 128));
			end else begin
				next_size = oaht_pkg::SIZE_W'($urandom_range(0, 511));
			end
			write_size(next_size);
			key_pool.delete();
			repeat ($urandom_range(8, 60)) key_pool.push_back(fresh_key());
			phase_words = $urandom_range(40, 120);
			for (int n = 0; n < phase_words; n++) begin
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 12);
					pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
				end
				burst_left--;
				w.command = 1'($urandom_range(0, 1));
				w.datum_in = $urandom;
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					w.key_bytes = key_pool[$urandom_range(0, key_pool.size() - 1)];
					seen_end = 1'b0;
					for (int i = 0; i < oaht_pkg::KEYIN_BYTES; i++) begin
						if (seen_end) begin
							w.key_bytes[8*i +: 8] = 8'($urandom_range(0, 255));
						end else if (w.key_bytes[8*i +: 8] == 8'd0) begin
							seen_end = 1'b1;
						end
					end
				end else if (pick < 9) begin
					w.key_bytes = fresh_key();
				end else begin
					w.key_bytes = {$urandom, $urandom};
				end
				send_word(w, 1'b0, '0);
				random_words++;
				if ($urandom_range(0, 49) == 0) begin
					drain();
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_replies.size() != 0) begin
			$error("%0d expected result words never arrived", pending_replies.size());
			errors++;
		end
		$display("Sent %0d words across %0d table-size writes.", words_sent, size_writes);
		$display("Results: %0d new, %0d replaced, %0d full, %0d found, %0d not found.",
			status_seen[oaht_pkg::ST_NEW], status_seen[oaht_pkg::ST_REPLACED],
			status_seen[oaht_pkg::ST_FULL], status_seen[oaht_pkg::ST_FOUND],
			status_seen[oaht_pkg::ST_MISSING]);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
